@@ rtl/psmac_pkg.sv @@
`default_nettype none

package psmac_pkg;

    localparam int BIN_W     = 10;
    localparam int SEG_W     = 4;
    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 18;
    localparam int CFG_W     = 5;
    localparam int OUT_W     = 32;
    localparam int ACC_W     = 48;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int OUT_SHIFT = 17;

    typedef enum logic
    {
        CMD_PROCESS = 1'b0,
        CMD_LOAD    = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_DRAIN
    } back_state_t;

    typedef struct packed
    {
        cmd_t                        command;
        logic [BIN_W-1:0]            bin_index;
        logic [SEG_W-1:0]            segment_index;
        logic signed [SAMPLE_W-1:0]  sample_re;
        logic signed [SAMPLE_W-1:0]  sample_im;
        logic signed [COEF_W-1:0]    coef_re;
        logic signed [COEF_W-1:0]    coef_im;
        logic                        last_bin;
    } item_t;

endpackage

`default_nettype wire

@@ rtl/psmac_ifs.sv @@
`default_nettype none

interface psmac_in_if;
    import psmac_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [BIN_W-1:0]            bin_index;
    logic [SEG_W-1:0]            segment_index;
    logic signed [SAMPLE_W-1:0]  sample_re;
    logic signed [SAMPLE_W-1:0]  sample_im;
    logic signed [COEF_W-1:0]    coef_re;
    logic signed [COEF_W-1:0]    coef_im;
    logic                        last_bin;

    modport source (output valid, command, bin_index, segment_index, sample_re, sample_im,
                    coef_re, coef_im, last_bin, input ready);
    modport sink (input valid, command, bin_index, segment_index, sample_re, sample_im,
                  coef_re, coef_im, last_bin, output ready);
endinterface

interface psmac_out_if;
    import psmac_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [OUT_W-1:0]   out_re;
    logic signed [OUT_W-1:0]   out_im;
    logic [BIN_W-1:0]          out_bin;
    logic                      frame_end;

    modport source (output valid, out_re, out_im, out_bin, frame_end, input ready);
    modport sink (input valid, out_re, out_im, out_bin, frame_end, output ready);
endinterface

`default_nettype wire

@@ rtl/psmac_queue.sv @@
`default_nettype none

module psmac_queue
    import psmac_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire item_t  push_item,
    output logic        full,
    output logic        q_valid,
    output item_t       q_item,
    input  wire logic   pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t           entry_reg [DEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   rptr_reg;
    logic [CW-1:0]   count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/psmac_front.sv @@
`default_nettype none

module psmac_front
    import psmac_pkg::*;
#(
    parameter int FRAME_LEN    = 512,
    parameter int MAX_SEGMENTS = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    psmac_in_if.sink   items,
    output logic       q_valid,
    output item_t      q_item,
    input  wire logic  q_pop
);

    item_t  in_item;
    logic   keep;
    logic   full;

    // Requests with a bin beyond the frame, or loads to a missing segment, are dropped here.
    always_comb
    begin
        in_item.command       = cmd_t'(items.command);
        in_item.bin_index     = items.bin_index;
        in_item.segment_index = items.segment_index;
        in_item.sample_re     = items.sample_re;
        in_item.sample_im     = items.sample_im;
        in_item.coef_re       = items.coef_re;
        in_item.coef_im       = items.coef_im;
        in_item.last_bin      = items.last_bin;
        keep = (32'(items.bin_index) <= 32'(FRAME_LEN));
        if ((in_item.command == CMD_LOAD) && (32'(items.segment_index) >= 32'(MAX_SEGMENTS)))
        begin
            keep = 1'b0;
        end
    end

    assign items.ready = !full;

    psmac_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (items.valid && !full && keep),
        .push_item (in_item),
        .full      (full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop)
    );

endmodule

`default_nettype wire

@@ rtl/psmac_back.sv @@
`default_nettype none

module psmac_back
    import psmac_pkg::*;
#(
    parameter int FRAME_LEN    = 512,
    parameter int MAX_SEGMENTS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              q_valid,
    input  wire item_t             q_item,
    output logic                   q_pop,
    psmac_out_if.source            results
);

    localparam int BINS   = FRAME_LEN + 1;
    localparam int FDEPTH = MAX_SEGMENTS * BINS;
    localparam int MDEPTH = (MAX_SEGMENTS + 1) * BINS;
    localparam int FAW    = $clog2(FDEPTH);
    localparam int MAW    = $clog2(MDEPTH);
    localparam int RW     = $clog2(MAX_SEGMENTS + 2);

    back_state_t state_reg;
    back_state_t state_next;

    logic [CFG_W-1:0]  seg_count_reg;
    logic [RW-1:0]     ring_position_reg;
    logic [RW-1:0]     segs_reg;
    logic [RW-1:0]     ring_reg;
    logic [RW-1:0]     pos_reg;
    logic [RW-1:0]     step_reg;
    logic [RW-1:0]     slot_reg;
    logic [RW-1:0]     segs_eff;
    logic [MAW-1:0]    clr_addr_reg;

    logic signed [SAMPLE_W-1:0]  xr_reg;
    logic signed [SAMPLE_W-1:0]  xi_reg;
    logic [BIN_W-1:0]            bin_reg;
    logic                        last_reg;

    logic                  issue;
    logic                  f_we;
    logic                  m_we;
    logic [FAW-1:0]        f_waddr;
    logic [FAW-1:0]        f_raddr;
    logic [MAW-1:0]        m_waddr;
    logic [MAW-1:0]        m_raddr;
    logic [2*COEF_W-1:0]   f_wdata;
    logic [2*ACC_W-1:0]    m_wdata;

    logic [2*COEF_W-1:0]   f_mem [FDEPTH];
    logic [2*ACC_W-1:0]    m_mem [MDEPTH];
    logic [2*COEF_W-1:0]   f_rd_reg;
    logic [2*ACC_W-1:0]    m_rd_reg;

    logic              p1_v_reg;
    logic              p1_first_reg;
    logic [MAW-1:0]    p1_addr_reg;
    logic              p2_v_reg;
    logic              p2_first_reg;
    logic [MAW-1:0]    p2_addr_reg;
    logic signed [PROD_W-1:0]  rr_reg;
    logic signed [PROD_W-1:0]  ii_reg;
    logic signed [PROD_W-1:0]  ri_reg;
    logic signed [PROD_W-1:0]  ir_reg;
    logic signed [ACC_W-1:0]   acc_re_reg;
    logic signed [ACC_W-1:0]   acc_im_reg;

    logic signed [SUM_W-1:0]  prod_re;
    logic signed [SUM_W-1:0]  prod_im;
    logic signed [ACC_W:0]    wide_re;
    logic signed [ACC_W:0]    wide_im;
    logic signed [ACC_W-1:0]  sum_re;
    logic signed [ACC_W-1:0]  sum_im;

    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  out_re_reg;
    logic signed [OUT_W-1:0]  out_im_reg;
    logic [BIN_W-1:0]         out_bin_reg;
    logic                     out_end_reg;

    always_comb
    begin
        if (seg_count_reg == '0)
        begin
            segs_eff = RW'(1);
        end
        else if (32'(seg_count_reg) > 32'(MAX_SEGMENTS))
        begin
            segs_eff = RW'(MAX_SEGMENTS);
        end
        else
        begin
            segs_eff = RW'(seg_count_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == MAW'(MDEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_pop && (q_item.command == CMD_PROCESS))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (pos_reg < ring_reg)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_reg == segs_reg - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!p1_v_reg && !p2_v_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop   = (state_reg == ST_IDLE) && q_valid
                  && ((q_item.command == CMD_LOAD) || !out_valid_reg);
        issue   = (state_reg == ST_RUN);
        f_we    = q_pop && (q_item.command == CMD_LOAD);
        f_waddr = FAW'(q_item.segment_index) * FAW'(BINS) + FAW'(q_item.bin_index);
        f_wdata = {q_item.coef_re, q_item.coef_im};
        f_raddr = FAW'(step_reg) * FAW'(BINS) + FAW'(bin_reg);
        m_raddr = MAW'(slot_reg) * MAW'(BINS) + MAW'(bin_reg);
        if (state_reg == ST_CLEAR)
        begin
            m_we    = 1'b1;
            m_waddr = clr_addr_reg;
            m_wdata = '0;
        end
        else
        begin
            m_we    = p2_v_reg;
            m_waddr = p2_addr_reg;
            m_wdata = p2_first_reg ? '0 : {sum_re, sum_im};
        end
    end

    always_comb
    begin
        prod_re = SUM_W'(rr_reg) - SUM_W'(ii_reg);
        prod_im = SUM_W'(ri_reg) + SUM_W'(ir_reg);
        wide_re = (ACC_W + 1)'(acc_re_reg) + (ACC_W + 1)'(prod_re);
        wide_im = (ACC_W + 1)'(acc_im_reg) + (ACC_W + 1)'(prod_im);
        if (wide_re[ACC_W] != wide_re[ACC_W-1])
        begin
            sum_re = wide_re[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sum_re = wide_re[ACC_W-1:0];
        end
        if (wide_im[ACC_W] != wide_im[ACC_W-1])
        begin
            sum_im = wide_im[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sum_im = wide_im[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            seg_count_reg     <= CFG_W'(1);
            ring_position_reg <= '0;
            clr_addr_reg      <= '0;
            p1_v_reg          <= 1'b0;
            p2_v_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                seg_count_reg <= cfg_data;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if ((state_reg == ST_PREP) && (pos_reg < ring_reg))
            begin
                if (last_reg)
                begin
                    ring_position_reg <= (pos_reg + 1'b1 == ring_reg) ? '0 : pos_reg + 1'b1;
                end
                else
                begin
                    ring_position_reg <= pos_reg;
                end
            end
            p1_v_reg <= issue;
            p2_v_reg <= p1_v_reg;
            if (p2_v_reg && p2_first_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            xr_reg   <= q_item.sample_re;
            xi_reg   <= q_item.sample_im;
            bin_reg  <= q_item.bin_index;
            last_reg <= q_item.last_bin;
            segs_reg <= segs_eff;
            ring_reg <= segs_eff + 1'b1;
            pos_reg  <= ring_position_reg;
        end
        else if (state_reg == ST_PREP)
        begin
            if (pos_reg >= ring_reg)
            begin
                pos_reg <= pos_reg - ring_reg;
            end
            else
            begin
                step_reg <= '0;
                slot_reg <= pos_reg;
            end
        end
        else if (issue)
        begin
            step_reg <= step_reg + 1'b1;
            slot_reg <= (slot_reg + 1'b1 == ring_reg) ? '0 : slot_reg + 1'b1;
        end

        p1_first_reg <= (step_reg == '0);
        p1_addr_reg  <= m_raddr;
        p2_first_reg <= p1_first_reg;
        p2_addr_reg  <= p1_addr_reg;
        rr_reg <= xr_reg * $signed(f_rd_reg[2*COEF_W-1:COEF_W]);
        ii_reg <= xi_reg * $signed(f_rd_reg[COEF_W-1:0]);
        ri_reg <= xr_reg * $signed(f_rd_reg[COEF_W-1:0]);
        ir_reg <= xi_reg * $signed(f_rd_reg[2*COEF_W-1:COEF_W]);
        acc_re_reg <= $signed(m_rd_reg[2*ACC_W-1:ACC_W]);
        acc_im_reg <= $signed(m_rd_reg[ACC_W-1:0]);

        if (p2_v_reg && p2_first_reg)
        begin
            out_re_reg  <= OUT_W'(sum_re >>> OUT_SHIFT);
            out_im_reg  <= OUT_W'(sum_im >>> OUT_SHIFT);
            out_bin_reg <= bin_reg;
            out_end_reg <= last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            f_mem[f_waddr] <= f_wdata;
        end
        f_rd_reg <= f_mem[f_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            m_mem[m_waddr] <= m_wdata;
        end
        m_rd_reg <= m_mem[m_raddr];
    end

    assign results.valid     = out_valid_reg;
    assign results.out_re    = out_re_reg;
    assign results.out_im    = out_im_reg;
    assign results.out_bin   = out_bin_reg;
    assign results.frame_end = out_end_reg;

`ifndef SYNTHESIS
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !q_pop)
        else $error("request taken during clearing pass");

    a_pipe_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        p2_v_reg |-> ((state_reg == ST_RUN) || (state_reg == ST_DRAIN)))
        else $error("accumulator write outside of a process request");

    a_slot_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> ((slot_reg < ring_reg) && (step_reg < segs_reg)))
        else $error("mixing slot or step outside the ring");

    a_result_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
        (p2_v_reg && p2_first_reg) |-> !out_valid_reg)
        else $error("result overwrites a waiting result");
`endif

endmodule

`default_nettype wire

@@ rtl/partitioned_spectral_mac_top.sv @@
// Process request: the result is registered from the first segment's MAC sum, since the
// emitted slot is the one the first segment updates.
// Process requests run one at a time, not while a result waits; a stale ring position is
// reduced; one shared complex MAC serves each segment; one load request per cycle if idle.
// Reset clears control state, then a clearing pass zeroes the (MAX_SEGMENTS + 1) *
// (FRAME_LEN + 1) mixing memory words; requests queue but are not executed until it ends.
`default_nettype none

module partitioned_spectral_mac_top
    import psmac_pkg::*;
#(
    parameter int FRAME_LEN    = 512,
    parameter int MAX_SEGMENTS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_data,
    psmac_in_if.sink               items,
    psmac_out_if.source            results
);

    logic   q_valid;
    logic   q_pop;
    item_t  q_item;

    psmac_front #(
        .FRAME_LEN    (FRAME_LEN),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    psmac_back #(
        .FRAME_LEN    (FRAME_LEN),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .results  (results)
    );

endmodule

`default_nettype wire

@@ dv/partitioned_spectral_mac_top_tb.sv @@
`timescale 1ns / 1ps

module partitioned_spectral_mac_top_tb;
    import psmac_pkg::*;

    localparam int NBINS    = 513;
    localparam int NSEGS    = 16;
    localparam longint ACC_HI = 64'sd140737488355327;
    localparam longint ACC_LO = -ACC_HI - 1;

    typedef struct
    {
        logic signed [OUT_W-1:0]  re;
        logic signed [OUT_W-1:0]  im;
        logic [BIN_W-1:0]         bin;
        logic                     fe;
    } bin_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_data;

    psmac_in_if  items_if ();
    psmac_out_if results_if ();

    partitioned_spectral_mac_top i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .items    (items_if),
        .results  (results_if)
    );

    logic signed [COEF_W-1:0]  coef_re_mem [NSEGS*NBINS];
    logic signed [COEF_W-1:0]  coef_im_mem [NSEGS*NBINS];
    bit                        coef_written [NSEGS*NBINS];
    longint                    mix_re [(NSEGS+1)*NBINS];
    longint                    mix_im [(NSEGS+1)*NBINS];
    int unsigned               ring_pos;
    logic [CFG_W-1:0]          seg_count;
    bin_result_t               pending_bins [$];

    int    mismatches;
    int    n_loads;
    int    n_process;
    int    n_results;
    int    n_cfg;
    int    burst_left;
    int    rx_cycle;
    int    pool [12] = '{0, 1, 2, 85, 170, 255, 256, 341, 384, 510, 511, 512};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int active_segs();
        int segs;
        segs = seg_count;
        if (segs < 1) segs = 1;
        if (segs > NSEGS) segs = NSEGS;
        return segs;
    endfunction

    function automatic longint sat48(longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    function automatic logic signed [OUT_W-1:0] scale_out(longint v);
        longint q;
        q = v >>> OUT_SHIFT;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[OUT_W-1:0];
    endfunction

    function automatic bit bin_ready(int bin);
        int segs;
        segs = active_segs();
        for (int s = 0; s < segs; s++)
            if (!coef_written[s*NBINS+bin]) return 0;
        return 1;
    endfunction

    function automatic void apply_request(item_t it);
        int          segs;
        int unsigned ring;
        int unsigned pos;
        int          k;
        longint      xr;
        longint      xi;
        longint      hr;
        longint      hi;
        bin_result_t r;
        if (it.bin_index > NBINS - 1) return;
        if (it.command == CMD_LOAD)
        begin
            k = it.segment_index * NBINS + it.bin_index;
            coef_re_mem[k] = it.coef_re;
            coef_im_mem[k] = it.coef_im;
            coef_written[k] = 1;
            n_loads++;
            return;
        end
        n_process++;
        segs = active_segs();
        ring = segs + 1;
        pos = ring_pos % ring;
        xr = it.sample_re;
        xi = it.sample_im;
        for (int s = 0; s < segs; s++)
        begin
            hr = coef_re_mem[s*NBINS+it.bin_index];
            hi = coef_im_mem[s*NBINS+it.bin_index];
            k = ((s + pos) % ring) * NBINS + it.bin_index;
            mix_re[k] = sat48(mix_re[k] + (xr * hr - xi * hi));
            mix_im[k] = sat48(mix_im[k] + (xr * hi + xi * hr));
        end
        k = pos * NBINS + it.bin_index;
        r.re = scale_out(mix_re[k]);
        r.im = scale_out(mix_im[k]);
        r.bin = it.bin_index;
        r.fe = it.last_bin;
        mix_re[k] = 0;
        mix_im[k] = 0;
        pending_bins.push_back(r);
        ring_pos = it.last_bin ? (pos + 1) % ring : pos;
    endfunction

    task automatic send_request(item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                items_if.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        items_if.valid         = 1'b1;
        items_if.command       = it.command;
        items_if.bin_index     = it.bin_index;
        items_if.segment_index = it.segment_index;
        items_if.sample_re     = it.sample_re;
        items_if.sample_im     = it.sample_im;
        items_if.coef_re       = it.coef_re;
        items_if.coef_im       = it.coef_im;
        items_if.last_bin      = it.last_bin;
        do @(posedge clk); while (!items_if.ready);
        apply_request(it);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        items_if.valid = 1'b0;
        while (pending_bins.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_seg_count(logic [CFG_W-1:0] value);
        wait_idle();
        cfg_we = 1'b1;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        seg_count = value;
        n_cfg++;
    endtask

    function automatic item_t load_item(int bin, int seg);
        item_t it;
        it = '0;
        it.command = CMD_LOAD;
        it.bin_index = BIN_W'(bin);
        it.segment_index = SEG_W'(seg);
        it.coef_re = COEF_W'($urandom);
        it.coef_im = COEF_W'($urandom);
        it.sample_re = SAMPLE_W'($urandom);
        it.sample_im = SAMPLE_W'($urandom);
        it.last_bin = ($urandom_range(0, 1) == 1);
        return it;
    endfunction

    function automatic item_t process_item(int bin, bit last);
        item_t it;
        it = '0;
        it.command = CMD_PROCESS;
        it.bin_index = BIN_W'(bin);
        it.segment_index = SEG_W'($urandom);
        it.sample_re = SAMPLE_W'($urandom);
        it.sample_im = SAMPLE_W'($urandom);
        it.coef_re = COEF_W'($urandom);
        it.coef_im = COEF_W'($urandom);
        it.last_bin = last;
        return it;
    endfunction

    task automatic test_load_filters();
        item_t it;
        foreach (pool[i])
            for (int s = 0; s < NSEGS; s++)
            begin
                it = load_item(pool[i], s);
                if (s == 0 && i < 4)
                begin
                    it.coef_re = (i % 2) ? 18'sh1ffff : -18'sh20000;
                    it.coef_im = (i % 2) ? -18'sh20000 : 18'sh1ffff;
                end
                send_request(it);
            end
    endtask

    task automatic test_extremes();
        item_t it;
        it = process_item(0, 0);
        it.sample_re = 24'sh7fffff;
        it.sample_im = -24'sh800000;
        send_request(it);
        it = process_item(512, 1);
        it.sample_re = -24'sh800000;
        it.sample_im = 24'sh7fffff;
        send_request(it);
        it = process_item(1, 1);
        it.sample_re = -24'sh800000;
        it.sample_im = -24'sh800000;
        send_request(it);
        send_request(process_item(513, 1));
        send_request(process_item(1023, 0));
        send_request(load_item(513, 3));
        send_request(load_item(1023, 15));
        it = load_item(512, 15);
        it.last_bin = 1;
        send_request(it);
        send_request(load_item(0, 0));
        for (int i = 0; i < 8; i++)
            send_request(process_item(pool[$urandom_range(0, 11)], i % 3 == 2));
    endtask

    task automatic test_saturation();
        item_t it;
        write_seg_count(5'd16);
        for (int i = 0; i < 80; i++)
        begin
            it = process_item(0, 0);
            it.sample_re = (i < 40) ? 24'sh7fffff : -24'sh800000;
            it.sample_im = (i < 40) ? -24'sh800000 : 24'sh7fffff;
            send_request(it);
        end
        for (int i = 0; i < 18; i++) send_request(process_item(0, 1));
    endtask

    task automatic test_segment_counts();
        logic [CFG_W-1:0] counts [6] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd2};
        foreach (counts[c])
        begin
            write_seg_count(counts[c]);
            for (int i = 0; i < 40; i++)
                send_request(process_item(pool[$urandom_range(0, 11)],
                                          $urandom_range(0, 3) == 0));
        end
    endtask

    task automatic test_random();
        int bin;
        int roll;
        for (int i = 0; i < 1500; i++)
        begin
            if (i % 400 == 399) write_seg_count(CFG_W'($urandom));
            roll = $urandom_range(0, 99);
            if (roll < 15)
                send_request(load_item($urandom_range(0, 512), $urandom_range(0, 15)));
            else if (roll < 20)
            begin
                send_request(process_item($urandom_range(513, 1023),
                                          $urandom_range(0, 1) == 1));
                i--;
            end
            else
            begin
                bin = $urandom_range(0, 512);
                if ($urandom_range(0, 3) != 0 || !bin_ready(bin))
                    bin = pool[$urandom_range(0, 11)];
                send_request(process_item(bin, $urandom_range(0, 7) == 0));
            end
        end
    endtask

    always @(negedge clk)
    begin
        rx_cycle++;
        case ((rx_cycle / 2500) % 3)
            0: results_if.ready <= 1'b1;
            1: results_if.ready <= ($urandom_range(0, 2) != 0);
            default: results_if.ready <= ((rx_cycle % 29) < 20);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
        begin
            n_results++;
            if (pending_bins.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result bin %0d", $realtime, results_if.out_bin);
            end
            else
            begin
                if (results_if.out_re !== pending_bins[0].re
                    || results_if.out_im !== pending_bins[0].im
                    || results_if.out_bin !== pending_bins[0].bin
                    || results_if.frame_end !== pending_bins[0].fe)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: bin %0d expected (%0d, %0d, fe %0b)",
                                  " got bin %0d (%0d, %0d, fe %0b)"},
                                 $realtime, pending_bins[0].bin, pending_bins[0].re,
                                 pending_bins[0].im, pending_bins[0].fe, results_if.out_bin,
                                 results_if.out_re, results_if.out_im, results_if.frame_end);
                end
                void'(pending_bins.pop_front());
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        items_if.valid = 1'b0;
        items_if.command = CMD_PROCESS;
        items_if.bin_index = '0;
        items_if.segment_index = '0;
        items_if.sample_re = '0;
        items_if.sample_im = '0;
        items_if.coef_re = '0;
        items_if.coef_im = '0;
        items_if.last_bin = 1'b0;
        results_if.ready = 1'b0;
        rx_cycle = 0;
        burst_left = 0;
        mismatches = 0;
        n_loads = 0;
        n_process = 0;
        n_results = 0;
        n_cfg = 0;
        ring_pos = 0;
        seg_count = 5'd1;
        foreach (mix_re[i])
        begin
            mix_re[i] = 0;
            mix_im[i] = 0;
        end
        foreach (coef_written[i]) coef_written[i] = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_load_filters();
        test_extremes();
        test_segment_counts();
        test_saturation();
        test_random();
        wait_idle();

        $display("Covered %0d filter loads, %0d processed bins and %0d checked results",
                 n_loads, n_process, n_results);
        $display("across %0d segment-count settings, including out-of-range counts.", n_cfg);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
